>>> rtl/pfp_pkg.sv
`timescale 1ns / 1ps

package pfp_pkg;

    // field widths
    localparam int CoordW = 32;
    localparam int EdgeW  = 33;
    localparam int ProdW  = 66;
    localparam int CrossW = 67;
    localparam int MagW   = 66;
    localparam int MantW  = 30;
    localparam int SqW    = 60;
    localparam int SumW   = 64;
    localparam int RootW  = 32;
    localparam int NumW   = 62;
    localparam int NormW  = 32;
    localparam int DotW   = 64;
    localparam int DistW  = 40;
    localparam int LenW   = 7;
    localparam int HalfW  = 33;
    localparam int HalfLenW = 6;

    // one point in signed q16.16
    typedef struct packed {
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
    } point_t;

    // data that rides alongside the square root and the dividers
    typedef struct packed {
        logic         deg;
        logic [2:0]   neg;
        point_t       pivot;
    } side_t;

    // word carried through the square root pipe
    typedef struct packed {
        side_t             side;
        logic [MantW-1:0]  mx;
        logic [MantW-1:0]  my;
        logic [MantW-1:0]  mz;
    } carry_t;

    // bit length of a 33-bit word
    function automatic logic [HalfLenW-1:0] bitlen33(input logic [HalfW-1:0] v);
        logic [HalfLenW-1:0] len;
        len = '0;
        for (int i = 0; i < HalfW; i++)
        begin
            if (v[i])
            begin
                len = HalfLenW'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

>>> rtl/pfp_front.sv
`timescale 1ns / 1ps

module pfp_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  pfp_pkg::point_t                  pa,
    input  pfp_pkg::point_t                  pb,
    input  pfp_pkg::point_t                  pc,
    output logic                             out_valid,
    output logic [pfp_pkg::SumW-1:0]         out_sum4,
    output pfp_pkg::carry_t                  out_carry
);

    localparam int Stages = 9;

    logic [Stages-1:0] vld_reg;

    // stage 1: edges
    logic signed [pfp_pkg::EdgeW-1:0] ex_reg, ey_reg, ez_reg, fx_reg, fy_reg, fz_reg;
    logic signed [pfp_pkg::EdgeW-1:0] ex_next, ey_next, ez_next, fx_next, fy_next, fz_next;
    pfp_pkg::point_t piv1_reg;

    // stage 2: partial products of the cross product
    logic signed [pfp_pkg::ProdW-1:0] prod_reg [0:5];
    logic signed [pfp_pkg::ProdW-1:0] prod_next [0:5];
    pfp_pkg::point_t piv2_reg;

    // stage 3: cross product
    logic signed [pfp_pkg::CrossW-1:0] cr_reg [0:2];
    logic signed [pfp_pkg::CrossW-1:0] cr_next [0:2];
    pfp_pkg::point_t piv3_reg;

    // stage 4: magnitudes and signs
    logic [pfp_pkg::MagW-1:0] mag4_reg [0:2];
    logic [pfp_pkg::MagW-1:0] mag4_next [0:2];
    logic [pfp_pkg::MagW-1:0] or4_reg, or4_next;
    logic [2:0] neg4_reg, neg4_next;
    pfp_pkg::point_t piv4_reg;

    // stage 5: bit lengths of the two halves
    logic [pfp_pkg::MagW-1:0] mag5_reg [0:2];
    logic [pfp_pkg::HalfLenW-1:0] lenh_reg, lenl_reg, lenh_next, lenl_next;
    logic [2:0] neg5_reg;
    pfp_pkg::point_t piv5_reg;

    // stage 6: common bit length
    logic [pfp_pkg::MagW-1:0] mag6_reg [0:2];
    logic [pfp_pkg::LenW-1:0] maxlen_reg, maxlen_next;
    logic [2:0] neg6_reg;
    pfp_pkg::point_t piv6_reg;

    // stage 7: scaled mantissas
    logic [pfp_pkg::MantW-1:0] m7_reg [0:2];
    logic [pfp_pkg::MantW-1:0] m7_next [0:2];
    pfp_pkg::side_t side7_reg, side7_next;

    // stage 8: squares
    logic [pfp_pkg::SqW-1:0] sq_reg [0:2];
    logic [pfp_pkg::SqW-1:0] sq_next [0:2];
    logic [pfp_pkg::MantW-1:0] m8_reg [0:2];
    pfp_pkg::side_t side8_reg;

    // stage 9: four times the squared norm
    logic [pfp_pkg::SumW-1:0] sum_reg, sum_next;
    logic [pfp_pkg::MantW-1:0] m9_reg [0:2];
    pfp_pkg::side_t side9_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[Stages-2:0], in_valid};
        end
    end

    // edges
    assign ex_next = pfp_pkg::EdgeW'(pa.x) - pfp_pkg::EdgeW'(pb.x);
    assign ey_next = pfp_pkg::EdgeW'(pa.y) - pfp_pkg::EdgeW'(pb.y);
    assign ez_next = pfp_pkg::EdgeW'(pa.z) - pfp_pkg::EdgeW'(pb.z);
    assign fx_next = pfp_pkg::EdgeW'(pc.x) - pfp_pkg::EdgeW'(pb.x);
    assign fy_next = pfp_pkg::EdgeW'(pc.y) - pfp_pkg::EdgeW'(pb.y);
    assign fz_next = pfp_pkg::EdgeW'(pc.z) - pfp_pkg::EdgeW'(pb.z);

    // products
    assign prod_next[0] = pfp_pkg::ProdW'(ey_reg) * pfp_pkg::ProdW'(fz_reg);
    assign prod_next[1] = pfp_pkg::ProdW'(ez_reg) * pfp_pkg::ProdW'(fy_reg);
    assign prod_next[2] = pfp_pkg::ProdW'(ez_reg) * pfp_pkg::ProdW'(fx_reg);
    assign prod_next[3] = pfp_pkg::ProdW'(ex_reg) * pfp_pkg::ProdW'(fz_reg);
    assign prod_next[4] = pfp_pkg::ProdW'(ex_reg) * pfp_pkg::ProdW'(fy_reg);
    assign prod_next[5] = pfp_pkg::ProdW'(ey_reg) * pfp_pkg::ProdW'(fx_reg);

    // differences
    assign cr_next[0] = pfp_pkg::CrossW'(prod_reg[0]) - pfp_pkg::CrossW'(prod_reg[1]);
    assign cr_next[1] = pfp_pkg::CrossW'(prod_reg[2]) - pfp_pkg::CrossW'(prod_reg[3]);
    assign cr_next[2] = pfp_pkg::CrossW'(prod_reg[4]) - pfp_pkg::CrossW'(prod_reg[5]);

    // sign and magnitude
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            neg4_next[i] = cr_reg[i][pfp_pkg::CrossW-1];
            mag4_next[i] = neg4_next[i] ? pfp_pkg::MagW'(-cr_reg[i])
                                        : pfp_pkg::MagW'(cr_reg[i]);
        end
        or4_next = mag4_next[0] | mag4_next[1] | mag4_next[2];
    end

    // half lengths
    assign lenh_next = pfp_pkg::bitlen33(or4_reg[pfp_pkg::MagW-1:pfp_pkg::HalfW]);
    assign lenl_next = pfp_pkg::bitlen33(or4_reg[pfp_pkg::HalfW-1:0]);

    // combined length
    assign maxlen_next = (lenh_reg != '0)
                       ? pfp_pkg::LenW'(lenh_reg) + pfp_pkg::LenW'(pfp_pkg::HalfW)
                       : pfp_pkg::LenW'(lenl_reg);

    // scale so that the largest component has exactly thirty bits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (maxlen_reg > pfp_pkg::LenW'(pfp_pkg::MantW))
            begin
                m7_next[i] = pfp_pkg::MantW'(mag6_reg[i] >>
                             (maxlen_reg - pfp_pkg::LenW'(pfp_pkg::MantW)));
            end
            else
            begin
                m7_next[i] = pfp_pkg::MantW'(mag6_reg[i] <<
                             (pfp_pkg::LenW'(pfp_pkg::MantW) - maxlen_reg));
            end
        end
        side7_next.deg   = (maxlen_reg == '0);
        side7_next.neg   = neg6_reg;
        side7_next.pivot = piv6_reg;
    end

    // squares
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = pfp_pkg::SqW'(m7_reg[i]) * pfp_pkg::SqW'(m7_reg[i]);
        end
    end

    // sum, times four
    assign sum_next = (pfp_pkg::SumW'(sq_reg[0]) + pfp_pkg::SumW'(sq_reg[1])
                     + pfp_pkg::SumW'(sq_reg[2])) << 2;

    // data registers
    always_ff @(posedge clk)
    begin
        ex_reg   <= ex_next;
        ey_reg   <= ey_next;
        ez_reg   <= ez_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        fz_reg   <= fz_next;
        piv1_reg <= pb;
        for (int i = 0; i < 6; i++)
        begin
            prod_reg[i] <= prod_next[i];
        end
        piv2_reg <= piv1_reg;
        for (int i = 0; i < 3; i++)
        begin
            cr_reg[i]   <= cr_next[i];
            mag4_reg[i] <= mag4_next[i];
            mag5_reg[i] <= mag4_reg[i];
            mag6_reg[i] <= mag5_reg[i];
            m7_reg[i]   <= m7_next[i];
            sq_reg[i]   <= sq_next[i];
            m8_reg[i]   <= m7_reg[i];
            m9_reg[i]   <= m8_reg[i];
        end
        piv3_reg   <= piv2_reg;
        or4_reg    <= or4_next;
        neg4_reg   <= neg4_next;
        piv4_reg   <= piv3_reg;
        lenh_reg   <= lenh_next;
        lenl_reg   <= lenl_next;
        neg5_reg   <= neg4_reg;
        piv5_reg   <= piv4_reg;
        maxlen_reg <= maxlen_next;
        neg6_reg   <= neg5_reg;
        piv6_reg   <= piv5_reg;
        side7_reg  <= side7_next;
        side8_reg  <= side7_reg;
        sum_reg    <= sum_next;
        side9_reg  <= side8_reg;
    end

    assign out_valid       = vld_reg[Stages-1];
    assign out_sum4        = sum_reg;
    assign out_carry.side  = side9_reg;
    assign out_carry.mx    = m9_reg[0];
    assign out_carry.my    = m9_reg[1];
    assign out_carry.mz    = m9_reg[2];

endmodule

>>> rtl/pfp_sqrt.sv
`timescale 1ns / 1ps

module pfp_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [pfp_pkg::SumW-1:0]      in_value,
    input  pfp_pkg::carry_t               in_carry,
    output logic                          out_valid,
    output logic [pfp_pkg::RootW-1:0]     out_root,
    output pfp_pkg::carry_t               out_carry
);

    localparam int Steps = pfp_pkg::RootW;
    localparam int RemW  = pfp_pkg::RootW + 4;

    logic [RemW-1:0]            rem_reg  [0:Steps-1];
    logic [pfp_pkg::RootW-1:0]  root_reg [0:Steps-1];
    logic [pfp_pkg::SumW-1:0]   val_reg  [0:Steps-1];
    pfp_pkg::carry_t            car_reg  [0:Steps-1];
    logic [Steps-1:0]           vld_reg;

    // one root bit per stage, two radicand bits consumed each time
    for (genvar k = 0; k < Steps; k++)
    begin : g_step
        logic [RemW-1:0]           rem_in, t, trial, rem_next;
        logic [pfp_pkg::RootW-1:0] root_in, root_next;
        logic [pfp_pkg::SumW-1:0]  val_in, val_next;
        pfp_pkg::carry_t           car_in;
        logic                      vld_in, ge;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = in_value;
            assign car_in  = in_carry;
            assign vld_in  = in_valid;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign val_in  = val_reg[k-1];
            assign car_in  = car_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign t         = {rem_in[RemW-3:0], val_in[pfp_pkg::SumW-1 -: 2]};
        assign trial     = {2'b00, root_in, 2'b01};
        assign ge        = (t >= trial);
        assign rem_next  = ge ? (t - trial) : t;
        assign root_next = {root_in[pfp_pkg::RootW-2:0], ge};
        assign val_next  = {val_in[pfp_pkg::SumW-3:0], 2'b00};

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            val_reg[k]  <= val_next;
            car_reg[k]  <= car_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end
    end

    assign out_valid = vld_reg[Steps-1];
    assign out_root  = root_reg[Steps-1];
    assign out_carry = car_reg[Steps-1];

endmodule

>>> rtl/pfp_div.sv
`timescale 1ns / 1ps

module pfp_div (
    input  logic                          clk,
    input  logic [pfp_pkg::NumW-1:0]      num,
    input  logic [pfp_pkg::RootW-1:0]     den,
    output logic [pfp_pkg::NormW-1:0]     quo
);

    localparam int Steps = pfp_pkg::NormW;
    localparam int W     = pfp_pkg::RootW;

    logic [W-1:0] rem_reg [0:Steps-1];
    logic [W-1:0] quo_reg [0:Steps-1];
    logic [W-1:0] low_reg [0:Steps-1];
    logic [W-1:0] den_reg [0:Steps-1];

    // restoring division, one quotient bit per stage
    for (genvar k = 0; k < Steps; k++)
    begin : g_step
        logic [W-1:0] rem_in, quo_in, low_in, den_in, rem_next, quo_next, low_next;
        logic [W:0]   t;
        logic         ge;

        if (k == 0)
        begin : g_first
            assign rem_in = W'(num[pfp_pkg::NumW-1:W]);
            assign quo_in = '0;
            assign low_in = num[W-1:0];
            assign den_in = den;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign low_in = low_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        assign t        = {rem_in, low_in[W-1]};
        assign ge       = (t >= {1'b0, den_in});
        assign rem_next = ge ? W'(t - {1'b0, den_in}) : t[W-1:0];
        assign quo_next = {quo_in[W-2:0], ge};
        assign low_next = {low_in[W-2:0], 1'b0};

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            quo_reg[k] <= quo_next;
            low_reg[k] <= low_next;
            den_reg[k] <= den_in;
        end
    end

    assign quo = quo_reg[Steps-1];

endmodule

>>> rtl/pfp_back.sv
`timescale 1ns / 1ps

module pfp_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [pfp_pkg::NormW-1:0]           qx,
    input  logic [pfp_pkg::NormW-1:0]           qy,
    input  logic [pfp_pkg::NormW-1:0]           qz,
    input  pfp_pkg::side_t                      side,
    output logic                                done,
    output logic signed [pfp_pkg::NormW-1:0]    normal_x,
    output logic signed [pfp_pkg::NormW-1:0]    normal_y,
    output logic signed [pfp_pkg::NormW-1:0]    normal_z,
    output logic signed [pfp_pkg::DistW-1:0]    plane_distance,
    output logic                                degenerate
);

    localparam logic [pfp_pkg::NormW-1:0] One     = pfp_pkg::NormW'(1) << 30;
    localparam logic [pfp_pkg::DotW-1:0]  Half    = pfp_pkg::DotW'(1) << 29;
    localparam logic [pfp_pkg::DotW-1:0]  NegLim  = pfp_pkg::DotW'(1) << 39;
    localparam logic [pfp_pkg::DotW-1:0]  PosLim  = (pfp_pkg::DotW'(1) << 39) - 1;

    logic [2:0] vld_reg;

    logic signed [pfp_pkg::NormW-1:0] n_reg [0:2];
    logic signed [pfp_pkg::NormW-1:0] n_next [0:2];
    logic signed [pfp_pkg::NormW-1:0] n2_reg [0:2];
    logic signed [pfp_pkg::NormW-1:0] n3_reg [0:2];
    logic signed [pfp_pkg::DotW-1:0]  pr_reg [0:2];
    logic signed [pfp_pkg::DotW-1:0]  pr_next [0:2];
    logic signed [pfp_pkg::DotW-1:0]  dot_reg, dot_next;
    pfp_pkg::side_t side1_reg, side2_reg, side3_reg;

    logic [pfp_pkg::DotW-1:0]         dmag, drnd;
    logic                             dneg;
    logic signed [pfp_pkg::DistW-1:0] dist_next;

    logic                             done_reg;
    logic signed [pfp_pkg::NormW-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [pfp_pkg::DistW-1:0] dist_reg;
    logic                             deg_reg;

    // clamp and apply sign
    always_comb
    begin
        logic [pfp_pkg::NormW-1:0] q [0:2];
        q[0] = qx;
        q[1] = qy;
        q[2] = qz;
        for (int i = 0; i < 3; i++)
        begin
            if (q[i] > One)
            begin
                q[i] = One;
            end
            n_next[i] = side.neg[i] ? -$signed(q[i]) : $signed(q[i]);
        end
    end

    // products with the pivot
    assign pr_next[0] = pfp_pkg::DotW'(side1_reg.pivot.x) * pfp_pkg::DotW'(n_reg[0]);
    assign pr_next[1] = pfp_pkg::DotW'(side1_reg.pivot.y) * pfp_pkg::DotW'(n_reg[1]);
    assign pr_next[2] = pfp_pkg::DotW'(side1_reg.pivot.z) * pfp_pkg::DotW'(n_reg[2]);

    assign dot_next = pr_reg[0] + pr_reg[1] + pr_reg[2];

    // round half away from zero to q16.16 and saturate
    always_comb
    begin
        dneg = dot_reg[pfp_pkg::DotW-1];
        dmag = dneg ? pfp_pkg::DotW'(-dot_reg) : pfp_pkg::DotW'(dot_reg);
        drnd = (dmag + Half) >> 30;
        if (dneg)
        begin
            if (drnd > NegLim)
            begin
                drnd = NegLim;
            end
            dist_next = -$signed(pfp_pkg::DistW'(drnd));
        end
        else
        begin
            if (drnd > PosLim)
            begin
                drnd = PosLim;
            end
            dist_next = $signed(pfp_pkg::DistW'(drnd));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[1:0], in_valid};
            done_reg <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_reg[i]  <= n_next[i];
            n2_reg[i] <= n_reg[i];
            n3_reg[i] <= n2_reg[i];
            pr_reg[i] <= pr_next[i];
        end
        side1_reg <= side;
        side2_reg <= side1_reg;
        side3_reg <= side2_reg;
        dot_reg   <= dot_next;
        // a degenerate word returns a zero normal and a zero distance
        nx_reg    <= side3_reg.deg ? '0 : n3_reg[0];
        ny_reg    <= side3_reg.deg ? '0 : n3_reg[1];
        nz_reg    <= side3_reg.deg ? '0 : n3_reg[2];
        dist_reg  <= side3_reg.deg ? '0 : dist_next;
        deg_reg   <= side3_reg.deg;
    end

    assign done           = done_reg;
    assign normal_x       = nx_reg;
    assign normal_y       = ny_reg;
    assign normal_z       = nz_reg;
    assign plane_distance = dist_reg;
    assign degenerate     = deg_reg;

endmodule

>>> rtl/plane_from_three_points_unit.sv
`timescale 1ns / 1ps

// plane through three points: takes A, B (pivot) and C in signed q16.16 and returns the
// unit normal of (A-B) x (C-B) in signed q1.30 and the distance B.n in signed q24.16 on
// 40 bits; collinear points give degenerate = 1 with all other results zero. a word is
// taken on every cycle that start is high (busy stays low) and its result is shown for one
// cycle with done high, in the same order, after passing the 32-stage square root pipe
// and the 32-stage dividers, one bit per stage, plus nine front stages (edges, cross
// product, normalisation), one stage forming the dividend and four back stages (clamp,
// dot product, rounding). the receiver cannot stall, so results must be taken as they come.

module plane_from_three_points_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [pfp_pkg::CoordW-1:0]   first_x,
    input  logic signed [pfp_pkg::CoordW-1:0]   first_y,
    input  logic signed [pfp_pkg::CoordW-1:0]   first_z,
    input  logic signed [pfp_pkg::CoordW-1:0]   second_x,
    input  logic signed [pfp_pkg::CoordW-1:0]   second_y,
    input  logic signed [pfp_pkg::CoordW-1:0]   second_z,
    input  logic signed [pfp_pkg::CoordW-1:0]   third_x,
    input  logic signed [pfp_pkg::CoordW-1:0]   third_y,
    input  logic signed [pfp_pkg::CoordW-1:0]   third_z,
    output logic                                done,
    output logic signed [pfp_pkg::NormW-1:0]    normal_x,
    output logic signed [pfp_pkg::NormW-1:0]    normal_y,
    output logic signed [pfp_pkg::NormW-1:0]    normal_z,
    output logic signed [pfp_pkg::DistW-1:0]    plane_distance,
    output logic                                degenerate
);

    localparam int DivSteps = pfp_pkg::NormW;

    pfp_pkg::point_t            pa, pb, pc;
    logic                       fr_valid, sq_valid;
    logic [pfp_pkg::SumW-1:0]   fr_sum4;
    pfp_pkg::carry_t            fr_carry, sq_carry;
    logic [pfp_pkg::RootW-1:0]  sq_root;

    logic [pfp_pkg::NumW-1:0]   num_reg [0:2];
    logic [pfp_pkg::NumW-1:0]   num_next [0:2];
    logic [pfp_pkg::RootW-1:0]  den_reg;
    pfp_pkg::side_t             prep_side_reg;
    logic                       prep_vld_reg;

    pfp_pkg::side_t             side_dly_reg [0:DivSteps-1];
    logic [DivSteps-1:0]        vld_dly_reg;

    logic [pfp_pkg::NormW-1:0]  qx, qy, qz;

    // pipeline never holds off a word
    assign busy = 1'b0;

    assign pa = '{x: first_x,  y: first_y,  z: first_z};
    assign pb = '{x: second_x, y: second_y, z: second_z};
    assign pc = '{x: third_x,  y: third_y,  z: third_z};

    // cross product and normalisation to thirty bits
    pfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .pa        (pa),
        .pb        (pb),
        .pc        (pc),
        .out_valid (fr_valid),
        .out_sum4  (fr_sum4),
        .out_carry (fr_carry)
    );

    // r = floor(sqrt(4 * |v|^2))
    pfp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_value  (fr_sum4),
        .in_carry  (fr_carry),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_carry (sq_carry)
    );

    // dividend m * 2^31 + r / 2 for rounding to nearest
    assign num_next[0] = pfp_pkg::NumW'({sq_carry.mx, 31'b0}) + pfp_pkg::NumW'(sq_root[31:1]);
    assign num_next[1] = pfp_pkg::NumW'({sq_carry.my, 31'b0}) + pfp_pkg::NumW'(sq_root[31:1]);
    assign num_next[2] = pfp_pkg::NumW'({sq_carry.mz, 31'b0}) + pfp_pkg::NumW'(sq_root[31:1]);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_reg[i] <= num_next[i];
        end
        den_reg         <= sq_root;
        prep_side_reg   <= sq_carry.side;
        side_dly_reg[0] <= prep_side_reg;
        for (int i = 1; i < DivSteps; i++)
        begin
            side_dly_reg[i] <= side_dly_reg[i-1];
        end
    end

    // valid bits alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_vld_reg <= 1'b0;
            vld_dly_reg  <= '0;
        end
        else
        begin
            prep_vld_reg <= sq_valid;
            vld_dly_reg  <= {vld_dly_reg[DivSteps-2:0], prep_vld_reg};
        end
    end

    pfp_div u_div_x (.clk(clk), .num(num_reg[0]), .den(den_reg), .quo(qx));
    pfp_div u_div_y (.clk(clk), .num(num_reg[1]), .den(den_reg), .quo(qy));
    pfp_div u_div_z (.clk(clk), .num(num_reg[2]), .den(den_reg), .quo(qz));

    // signs, distance and output registers
    pfp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (vld_dly_reg[DivSteps-1]),
        .qx             (qx),
        .qy             (qy),
        .qz             (qz),
        .side           (side_dly_reg[DivSteps-1]),
        .done           (done),
        .normal_x       (normal_x),
        .normal_y       (normal_y),
        .normal_z       (normal_z),
        .plane_distance (plane_distance),
        .degenerate     (degenerate)
    );

    // degenerate words carry no normal and no distance
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> normal_x == 0 && normal_y == 0 && normal_z == 0
                               && plane_distance == 0)
        else $error("degenerate result with non-zero fields");

    // unit normal components stay within plus or minus one
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> normal_x <= 32'sd1073741824 && normal_x >= -32'sd1073741824
              && normal_y <= 32'sd1073741824 && normal_y >= -32'sd1073741824
              && normal_z <= 32'sd1073741824 && normal_z >= -32'sd1073741824)
        else $error("normal component out of range");

    // a proper plane has a non-zero normal
    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !degenerate |-> normal_x != 0 || normal_y != 0 || normal_z != 0)
        else $error("zero normal on a non-degenerate result");

endmodule

>>> tb/sv/plane_from_three_points_unit_test.sv
`timescale 1ns / 1ps

module plane_from_three_points_unit_test;

    localparam int  Latency    = 78;
    localparam int  RandWords  = 1950;
    localparam longint Limit   = 400000;

    // one result word
    typedef struct {
        logic signed [pfp_pkg::NormW-1:0] nx;
        logic signed [pfp_pkg::NormW-1:0] ny;
        logic signed [pfp_pkg::NormW-1:0] nz;
        logic signed [pfp_pkg::DistW-1:0] pdist;
        logic                             deg;
    } plane_t;

    // one directed row: points plus optional typed-in expectation
    typedef struct {
        logic signed [pfp_pkg::CoordW-1:0] p [9];
        bit                                typed;
        plane_t                            res;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [pfp_pkg::CoordW-1:0] first_x = '0, first_y = '0, first_z = '0;
    logic signed [pfp_pkg::CoordW-1:0] second_x = '0, second_y = '0, second_z = '0;
    logic signed [pfp_pkg::CoordW-1:0] third_x = '0, third_y = '0, third_z = '0;
    logic done;
    logic signed [pfp_pkg::NormW-1:0] normal_x, normal_y, normal_z;
    logic signed [pfp_pkg::DistW-1:0] plane_distance;
    logic degenerate;

    plane_t planes_due [$];
    int     errors = 0;
    int     words_sent = 0;
    int     words_seen = 0;
    int     degen_seen = 0;
    longint cycles = 0;

    plane_from_three_points_unit i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > Limit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // plane through the three points, bit exact
    function automatic plane_t plane_of(input logic signed [pfp_pkg::CoordW-1:0] p [9]);
        plane_t r;
        logic signed [pfp_pkg::EdgeW-1:0]  e [3];
        logic signed [pfp_pkg::EdgeW-1:0]  f [3];
        logic signed [pfp_pkg::CrossW-1:0] cr [3];
        logic [pfp_pkg::MagW:0]            mag [3];
        logic [63:0]                       m [3];
        logic [63:0]                       sum, rem, root, bitv, q;
        logic signed [63:0]                n [3];
        logic signed [127:0]               dot;
        logic [127:0]                      dmag;
        bit                                neg [3];
        int                                maxlen;
        maxlen = 0;
        r = '{default: '0};
        for (int i = 0; i < 3; i++)
        begin
            e[i] = pfp_pkg::EdgeW'(p[i]) - pfp_pkg::EdgeW'(p[3+i]);
            f[i] = pfp_pkg::EdgeW'(p[6+i]) - pfp_pkg::EdgeW'(p[3+i]);
        end
        cr[0] = pfp_pkg::CrossW'(e[1]) * pfp_pkg::CrossW'(f[2])
              - pfp_pkg::CrossW'(e[2]) * pfp_pkg::CrossW'(f[1]);
        cr[1] = pfp_pkg::CrossW'(e[2]) * pfp_pkg::CrossW'(f[0])
              - pfp_pkg::CrossW'(e[0]) * pfp_pkg::CrossW'(f[2]);
        cr[2] = pfp_pkg::CrossW'(e[0]) * pfp_pkg::CrossW'(f[1])
              - pfp_pkg::CrossW'(e[1]) * pfp_pkg::CrossW'(f[0]);
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = cr[i][pfp_pkg::CrossW-1];
            mag[i] = neg[i] ? -cr[i] : cr[i];
            for (int b = 0; b <= pfp_pkg::MagW; b++)
            begin
                if (mag[i][b] && b + 1 > maxlen)
                begin
                    maxlen = b + 1;
                end
            end
        end
        if (maxlen == 0)
        begin
            r.deg = 1'b1;
            return r;
        end
        // scale so the largest magnitude is exactly 30 bits
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (maxlen >= 30)
            begin
                m[i] = 64'(mag[i] >> (maxlen - 30));
            end
            else
            begin
                m[i] = 64'(mag[i]) << (30 - maxlen);
            end
            m[i] &= (64'd1 << 30) - 1;
            sum += m[i] * m[i];
        end
        // integer square root of 4*sum
        rem = sum << 2;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
        begin
            bitv >>= 2;
        end
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
            begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << 31) + (root >> 1)) / root;
            if (q > (64'd1 << 30))
            begin
                q = 64'd1 << 30;
            end
            n[i] = neg[i] ? -$signed(q) : $signed(q);
        end
        r.nx = n[0][pfp_pkg::NormW-1:0];
        r.ny = n[1][pfp_pkg::NormW-1:0];
        r.nz = n[2][pfp_pkg::NormW-1:0];
        dot = 128'(p[3]) * 128'(n[0]) + 128'(p[4]) * 128'(n[1]) + 128'(p[5]) * 128'(n[2]);
        dmag = dot < 0 ? -dot : dot;
        dmag = (dmag + (128'd1 << 29)) >> 30;
        if (dot < 0)
        begin
            if (dmag > (128'd1 << 39))
            begin
                dmag = 128'd1 << 39;
            end
            r.pdist = -pfp_pkg::DistW'(dmag);
        end
        else
        begin
            if (dmag > (128'd1 << 39) - 1)
            begin
                dmag = (128'd1 << 39) - 1;
            end
            r.pdist = pfp_pkg::DistW'(dmag);
        end
        return r;
    endfunction

    // send one word and queue its expected plane
    task automatic send_word(input logic signed [pfp_pkg::CoordW-1:0] p [9],
                             input plane_t want);
        int   gap;
        logic held;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 2) == 0)
        begin
            gap = 0;
        end
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        first_x  <= p[0];
        first_y  <= p[1];
        first_z  <= p[2];
        second_x <= p[3];
        second_y <= p[4];
        second_z <= p[5];
        third_x  <= p[6];
        third_y  <= p[7];
        third_z  <= p[8];
        start    <= 1'b1;
        do
        begin
            held = busy;
            @(posedge clk);
        end
        while (held);
        planes_due.push_back(want);
        words_sent++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        plane_t want;
        if (rst_n && done)
        begin
            words_seen++;
            if (degenerate)
            begin
                degen_seen++;
            end
            if (planes_due.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                want = planes_due.pop_front();
                if (normal_x !== want.nx)
                begin
                    $error("normal_x expected %0d actual %0d", want.nx, normal_x);
                    errors++;
                end
                if (normal_y !== want.ny)
                begin
                    $error("normal_y expected %0d actual %0d", want.ny, normal_y);
                    errors++;
                end
                if (normal_z !== want.nz)
                begin
                    $error("normal_z expected %0d actual %0d", want.nz, normal_z);
                    errors++;
                end
                if (plane_distance !== want.pdist)
                begin
                    $error("plane_distance expected %0d actual %0d", want.pdist,
                           plane_distance);
                    errors++;
                end
                if (degenerate !== want.deg)
                begin
                    $error("degenerate expected %0b actual %0b", want.deg, degenerate);
                    errors++;
                end
            end
        end
    end

    // random coordinate: full range, small, whole numbers up to 255, or an extreme
    function automatic logic signed [pfp_pkg::CoordW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $signed($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
            1: return $signed($urandom_range(0, 65535)) - 32768;
            2: return $signed($urandom_range(0, 255)) <<< 16;
            default: return $signed($urandom());
        endcase
    endfunction

    initial
    begin
        row_t rows [$];
        row_t row;
        logic signed [pfp_pkg::CoordW-1:0] p [9];
        int k;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        row.typed = 1'b1;
        row.res = '{nx: 0, ny: 0, nz: 0, pdist: 0, deg: 1'b1};
        row.p = '{default: 0};
        rows.push_back(row);
        row.p = '{default: 32'sh7fffffff};
        rows.push_back(row);
        row.p = '{default: 32'sh80000000};
        rows.push_back(row);
        // collinear along x
        row.p = '{32'sh10000, 0, 0, 0, 0, 0, 32'sh30000, 0, 0};
        rows.push_back(row);
        // xy plane through origin: e along x, f along y gives +z
        row.res = '{nx: 0, ny: 0, nz: 32'sh40000000, pdist: 0, deg: 1'b0};
        row.p = '{32'sh10000, 0, 0, 0, 0, 0, 0, 32'sh10000, 0};
        rows.push_back(row);
        row.res = '{nx: 0, ny: 0, nz: -32'sh40000000, pdist: 0, deg: 1'b0};
        row.p = '{0, 32'sh10000, 0, 0, 0, 0, 32'sh10000, 0, 0};
        rows.push_back(row);
        row.typed = 1'b0;
        row.p = '{32'sh7fffffff, 32'sh80000000, 0, 32'sh80000000, 32'sh7fffffff, 0,
                  0, 0, 32'sh7fffffff};
        rows.push_back(row);
        row.p = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                  32'sh80000000};
        rows.push_back(row);
        row.p = '{1, 0, 0, 0, 0, 0, 0, 1, 0};
        rows.push_back(row);
        row.p = '{32'sh7fffffff, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                  0, 32'sh7fffffff, 32'sh7fffffff};
        rows.push_back(row);
        row.p = '{-1, -1, -1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 5, -3};
        rows.push_back(row);
        row.p = '{3, 7, 11, 32'sh12340000, -32'sh5670000, 32'sh9abc, 1, 1, 1};
        rows.push_back(row);
        foreach (rows[i])
        begin
            send_word(rows[i].p, rows[i].typed ? rows[i].res : plane_of(rows[i].p));
        end

        // random words, some collinear
        for (int n = 0; n < RandWords; n++)
        begin
            for (int i = 0; i < 9; i++)
            begin
                p[i] = rand_coord();
            end
            if ($urandom_range(0, 9) == 0)
            begin
                // third point on the line through the first two
                k = $urandom_range(0, 3) - 1;
                for (int i = 0; i < 3; i++)
                begin
                    p[3+i] = $signed($urandom_range(0, 65535)) - 32768;
                    p[i] = p[3+i] + $signed($urandom_range(0, 4095)) - 2048;
                    p[6+i] = p[3+i] + k * (p[i] - p[3+i]);
                end
            end
            send_word(p, plane_of(p));
        end
        start <= 1'b0;

        while (planes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (Latency + 10) @(posedge clk);
        $display("sent %0d words, checked %0d results (%0d degenerate)",
                 words_sent, words_seen, degen_seen);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/pfp_pkg.sv
rtl/pfp_front.sv
rtl/pfp_sqrt.sv
rtl/pfp_div.sv
rtl/pfp_back.sv
rtl/plane_from_three_points_unit.sv
tb/sv/plane_from_three_points_unit_test.sv
